/* rtl/pes_video_payload_extractor_core_assert.svh */
// Assertion macros shared by the extractor RTL.
`ifndef PES_VIDEO_PAYLOAD_EXTRACTOR_CORE_ASSERT_SVH
`define PES_VIDEO_PAYLOAD_EXTRACTOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define PVPE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PVPE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pvpe_pkg.sv */
// Types and constants of the PES video payload extractor.
package pvpe_pkg;

    localparam int MAX_BUFFER = 65536;
    localparam int MIN_LENGTH = 188;

    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 32;
    localparam int PADDR_W     = 3;

    // register index taken from paddr[2]
    localparam logic REG_IDX_BUF_LEN = 1'b0;

    localparam logic [23:0] START_CODE  = 24'h000001;
    localparam logic [23:0] WINDOW_IDLE = 24'hFFFFFF;
    localparam logic [3:0]  VIDEO_NIB   = 4'hE;
    localparam logic [1:0]  M2_MARK     = 2'b10;
    localparam logic [1:0]  STD_MARK    = 2'b01;
    localparam logic [3:0]  PTS_NIB     = 4'h2;
    localparam logic [3:0]  PTSDTS_NIB  = 4'h3;
    localparam logic [7:0]  STUFF_BYTE  = 8'hFF;
    localparam logic [7:0]  PRIV_ID_LO  = 8'hBD;
    localparam logic [7:0]  PRIV_ID_HI  = 8'hDF;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_LEN = 2'd1;
    localparam logic [1:0] ST_SHORT   = 2'd2;
    localparam logic [1:0] ST_NOT_PES = 2'd3;

    typedef enum logic [3:0] {
        PH_FIRST    = 4'd0,
        PH_SCAN     = 4'd1,
        PH_ID       = 4'd2,
        PH_LENHI    = 4'd3,
        PH_LENLO    = 4'd4,
        PH_SKIP     = 4'd5,
        PH_HDR      = 4'd6,
        PH_M2FLAGS  = 4'd7,
        PH_M2HLEN   = 4'd8,
        PH_M1STUFF  = 4'd9,
        PH_M1STD    = 4'd10,
        PH_M1PTS    = 4'd11,
        PH_HDRSKIP  = 4'd12,
        PH_PAYLOAD  = 4'd13,
        PH_HALT     = 4'd14
    } phase_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] payload_length;
        logic        is_end;
        logic        has_byte;
        logic [7:0]  payload_byte;
    } result_t;

endpackage

/* rtl/pvpe_parse.sv */
// Front end: PES parser, one byte per accepted request.
`include "pes_video_payload_extractor_core_assert.svh"

module pvpe_parse (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [15:0]       cfg_len,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output logic              res_valid,
    output pvpe_pkg::result_t res
);
    import pvpe_pkg::*;

    logic [15:0] pos_reg, pos_next;
    logic [23:0] win_reg, win_next;
    phase_t      phase_reg, phase_next;
    logic [15:0] prem_reg, prem_next;
    logic [15:0] skip_reg, skip_next;
    logic [7:0]  sid_reg, sid_next;
    logic [15:0] ecnt_reg, ecnt_next;
    logic [1:0]  rstat_reg, rstat_next;

    logic [15:0] len_eff;
    logic        acc;
    logic        pre_halt;
    logic        active;
    logic        emit;
    logic [23:0] win_shift;
    logic [16:0] pos_x;
    logic [16:0] len_x;
    logic        stuff_take, std_take, pts_take, dts_take;
    logic        do_pts;
    logic        fin_go;
    logic [8:0]  fin_sub;
    logic        fin_k2;
    logic [7:0]  fin_skip;
    logic signed [18:0] fin_len;
    logic [17:0] fin_end;
    logic [17:0] fin_cnt;
    logic        fin_bad;
    logic [15:0] skip_dec;
    logic [15:0] prem_dec;
    logic [15:0] lenlo_val;
    logic [1:0]  st;

    assign len_eff = ({16'b0, cfg_len} > 32'(MAX_BUFFER)) ? 16'(MAX_BUFFER) : cfg_len;
    assign acc     = in_valid && in_ready;
    assign pos_x   = {1'b0, pos_reg};
    assign len_x   = {1'b0, len_eff};

    assign win_shift = {win_reg[15:0], in_byte};
    assign skip_dec  = skip_reg - 16'd1;
    assign prem_dec  = prem_reg - 16'd1;
    assign lenlo_val = {prem_reg[15:8], in_byte};

    // MPEG-1 header field detection
    assign stuff_take = (prem_reg != 16'd0) && (in_byte == STUFF_BYTE);
    assign std_take   = (pos_x + 17'd2 <= len_x) && (prem_reg >= 16'd2)
                        && (in_byte[7:6] == STD_MARK);
    assign pts_take   = (pos_x + 17'd5 <= len_x) && (prem_reg >= 16'd5)
                        && (in_byte[7:4] == PTS_NIB);
    assign dts_take   = (pos_x + 17'd10 <= len_x) && (prem_reg >= 16'd10)
                        && (in_byte[7:4] == PTSDTS_NIB);

    // header close: remaining payload and buffer-end checks
    assign fin_len = $signed({3'b0, prem_reg}) - $signed({10'b0, fin_sub});
    assign fin_end = {2'b0, pos_reg} + {2'b0, prem_reg} - (fin_k2 ? 18'd2 : 18'd0);
    assign fin_cnt = {2'b0, ecnt_reg} + fin_len[17:0];
    assign fin_bad = fin_len[18] || (fin_cnt > {2'b0, len_eff})
                     || (fin_end > {2'b0, len_eff});

    always_comb begin
        pos_next   = pos_reg;
        win_next   = win_reg;
        phase_next = phase_reg;
        prem_next  = prem_reg;
        skip_next  = skip_reg;
        sid_next   = sid_reg;
        ecnt_next  = ecnt_reg;
        rstat_next = rstat_reg;
        emit       = 1'b0;
        do_pts     = 1'b0;
        fin_go     = 1'b0;
        fin_sub    = 9'd0;
        fin_k2     = 1'b0;
        fin_skip   = 8'd0;
        st         = ST_OK;

        pre_halt = (phase_reg == PH_FIRST) && (pos_reg == 16'd0)
                   && ({16'b0, len_eff} < 32'(MIN_LENGTH));
        if (pre_halt) begin
            phase_next = PH_HALT;
            rstat_next = ST_SHORT;
        end

        active = (pos_reg < len_eff) && (phase_reg != PH_HALT) && !pre_halt;

        if (active) begin
            unique case (phase_reg)
                PH_FIRST: begin
                    win_next = win_shift;
                    if (pos_reg < 16'd2) begin
                        if (in_byte != 8'd0) begin
                            phase_next = PH_HALT;
                            rstat_next = ST_NOT_PES;
                        end
                    end else if (pos_reg == 16'd2) begin
                        if (in_byte != 8'd1) begin
                            phase_next = PH_HALT;
                            rstat_next = ST_NOT_PES;
                        end
                    end else if (in_byte[7:4] != VIDEO_NIB) begin
                        phase_next = PH_HALT;
                        rstat_next = ST_NOT_PES;
                    end else begin
                        sid_next   = in_byte;
                        phase_next = (len_eff > 16'd6) ? PH_LENHI : PH_SCAN;
                    end
                end
                PH_SCAN: begin
                    win_next = win_shift;
                    if (win_shift == START_CODE && pos_x + 17'd4 < len_x) begin
                        phase_next = PH_ID;
                    end
                end
                PH_ID: begin
                    win_next = win_shift;
                    sid_next = in_byte;
                    if (in_byte[7:4] == VIDEO_NIB
                        || (in_byte >= PRIV_ID_LO && in_byte <= PRIV_ID_HI)) begin
                        phase_next = PH_LENHI;
                    end else begin
                        phase_next = PH_SCAN;
                    end
                end
                PH_LENHI: begin
                    prem_next  = {in_byte, 8'h00};
                    phase_next = PH_LENLO;
                end
                PH_LENLO: begin
                    prem_next = lenlo_val;
                    if (sid_reg[7:4] == VIDEO_NIB) begin
                        phase_next = PH_HDR;
                    end else if (lenlo_val == 16'd0) begin
                        win_next   = WINDOW_IDLE;
                        phase_next = PH_SCAN;
                    end else begin
                        skip_next  = lenlo_val;
                        phase_next = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0) begin
                        win_next   = WINDOW_IDLE;
                        phase_next = PH_SCAN;
                    end
                end
                PH_HDR, PH_M1STUFF: begin
                    if (phase_reg == PH_HDR && in_byte[7:6] == M2_MARK) begin
                        phase_next = PH_M2FLAGS;
                    end else if (stuff_take) begin
                        prem_next  = prem_dec;
                        phase_next = PH_M1STUFF;
                    end else if (std_take) begin
                        prem_next  = prem_reg - 16'd2;
                        phase_next = PH_M1STD;
                    end else begin
                        do_pts = 1'b1;
                    end
                end
                PH_M2FLAGS: begin
                    phase_next = PH_M2HLEN;
                end
                PH_M2HLEN: begin
                    if ({8'b0, in_byte} >= len_eff) begin
                        phase_next = PH_HALT;
                        rstat_next = ST_BAD_LEN;
                    end else begin
                        fin_go   = 1'b1;
                        fin_sub  = 9'd3 + {1'b0, in_byte};
                        fin_k2   = 1'b1;
                        fin_skip = in_byte;
                    end
                end
                PH_M1STD: begin
                    phase_next = PH_M1PTS;
                end
                PH_M1PTS: begin
                    do_pts = 1'b1;
                end
                PH_HDRSKIP: begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0) begin
                        if (prem_reg != 16'd0) begin
                            phase_next = PH_PAYLOAD;
                        end else begin
                            win_next   = WINDOW_IDLE;
                            phase_next = PH_SCAN;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    emit      = 1'b1;
                    ecnt_next = ecnt_reg + 16'd1;
                    prem_next = prem_dec;
                    if (prem_dec == 16'd0) begin
                        win_next   = WINDOW_IDLE;
                        phase_next = PH_SCAN;
                    end
                end
                PH_HALT: begin
                end
                default: begin
                    phase_next = PH_HALT;
                    rstat_next = ST_BAD_LEN;
                end
            endcase
        end

        // PTS / PTS+DTS / marker byte, or an empty MPEG-1 packet
        if (do_pts) begin
            if (pts_take) begin
                fin_go   = 1'b1;
                fin_sub  = 9'd5;
                fin_skip = 8'd4;
            end else if (dts_take) begin
                fin_go   = 1'b1;
                fin_sub  = 9'd10;
                fin_skip = 8'd9;
            end else if (prem_reg != 16'd0) begin
                fin_go  = 1'b1;
                fin_sub = 9'd1;
            end else begin
                win_next   = {16'hFFFF, in_byte};
                phase_next = PH_SCAN;
            end
        end

        if (fin_go) begin
            if (fin_bad) begin
                phase_next = PH_HALT;
                rstat_next = ST_BAD_LEN;
            end else begin
                prem_next = fin_len[15:0];
                skip_next = {8'b0, fin_skip};
                if (fin_skip != 8'd0) begin
                    phase_next = PH_HDRSKIP;
                end else if (fin_len != 19'sd0) begin
                    phase_next = PH_PAYLOAD;
                end else begin
                    win_next   = WINDOW_IDLE;
                    phase_next = PH_SCAN;
                end
            end
        end

        if (pos_reg != 16'hFFFF) begin
            pos_next = pos_reg + 16'd1;
        end

        // closing status from the state after this byte
        st = rstat_next;
        if (rstat_next == ST_OK) begin
            unique case (phase_next) inside
                PH_FIRST: begin
                    st = ST_NOT_PES;
                end
                PH_HDR, PH_M2FLAGS, PH_M2HLEN, PH_M1STD, PH_HDRSKIP, PH_PAYLOAD: begin
                    st = ST_BAD_LEN;
                end
                PH_M1STUFF, PH_M1PTS: begin
                    if (prem_next != 16'd0) begin
                        st = ST_BAD_LEN;
                    end
                end
                default: begin
                end
            endcase
        end

        res.payload_byte   = emit ? in_byte : 8'd0;
        res.has_byte       = emit;
        res.is_end         = in_last;
        res.payload_length = in_last ? ecnt_next : 16'd0;
        res.status         = in_last ? st : ST_OK;
        res_valid          = acc && (emit || in_last);

        if (in_last) begin
            pos_next   = 16'd0;
            win_next   = WINDOW_IDLE;
            phase_next = PH_FIRST;
            prem_next  = 16'd0;
            skip_next  = 16'd0;
            sid_next   = 8'd0;
            ecnt_next  = 16'd0;
            rstat_next = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 16'd0;
            win_reg   <= WINDOW_IDLE;
            phase_reg <= PH_FIRST;
            prem_reg  <= 16'd0;
            skip_reg  <= 16'd0;
            sid_reg   <= 8'd0;
            ecnt_reg  <= 16'd0;
            rstat_reg <= ST_OK;
        end else if (acc) begin
            pos_reg   <= pos_next;
            win_reg   <= win_next;
            phase_reg <= phase_next;
            prem_reg  <= prem_next;
            skip_reg  <= skip_next;
            sid_reg   <= sid_next;
            ecnt_reg  <= ecnt_next;
            rstat_reg <= rstat_next;
        end
    end

    `PVPE_ASSERT_NEXT(a_end_clears, aclk, aresetn, acc && in_last,
        pos_reg == 16'd0 && phase_reg == PH_FIRST && ecnt_reg == 16'd0,
        "buffer state not cleared after closing byte")
    `PVPE_ASSERT_NOW(a_byte_from_payload, aclk, aresetn, res_valid && res.has_byte,
        phase_reg == PH_PAYLOAD, "payload byte emitted outside payload phase")
    `PVPE_ASSERT_NOW(a_halt_has_status, aclk, aresetn, phase_reg == PH_HALT,
        rstat_reg != ST_OK, "halted without an error status")

endmodule

/* rtl/pvpe_queue.sv */
// Small result queue between the parser and the output stage.
`include "pes_video_payload_extractor_core_assert.svh"

module pvpe_queue #(
    parameter int DEPTH = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  pvpe_pkg::result_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output pvpe_pkg::result_t rd_data
);
    import pvpe_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    result_t       slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign rd_data   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `PVPE_ASSERT_NOW(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CW'(DEPTH),
        "queue count beyond depth")
    `PVPE_ASSERT_NOW(a_pop_nonempty, aclk, aresetn, pop, cnt_reg != '0,
        "pop from empty queue")
    `PVPE_ASSERT_NEXT(a_pop_drains, aclk, aresetn, pop && !push,
        cnt_reg == $past(cnt_reg) - CW'(1), "pop without push did not drain one")

endmodule

/* rtl/pvpe_out.sv */
// Back end: output register driving the result stream.
module pvpe_out (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               q_valid,
    input  pvpe_pkg::result_t                  q_data,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pvpe_pkg::TDATA_OUT_W-1:0]   m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast
);
    import pvpe_pkg::*;

    logic                   valid_reg, valid_next;
    logic [TDATA_OUT_W-1:0] data_reg;
    logic                   user_reg;
    logic                   last_reg;

    assign q_pop = q_valid && (!valid_reg || m_tready);

    always_comb begin
        valid_next = valid_reg;
        if (q_pop) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // tdata: payload_byte, payload_length, status, zero fill
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            data_reg <= {6'b0, q_data.status, q_data.payload_length, q_data.payload_byte};
            user_reg <= q_data.has_byte;
            last_reg <= q_data.is_end;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

/* rtl/pes_video_payload_extractor_core.sv */
// Top level of the PES video payload extractor.
//
// Usage:
//  - Write buffer_length (APB, byte address 0, bits 15:0) while the block is idle,
//    then stream the buffer on the s_ channel, one byte per request, tlast on the
//    final byte.
//  - The m_ channel carries one request per payload byte (tuser high) and one
//    closing request (tlast high) with the payload count and status; both may
//    share one request when the final byte is also a payload byte.
//  - Throughput: one input byte per clock while the queue has room. The parser
//    decides a byte in the cycle it is accepted.
//  - A result is written into the queue at the edge that accepts its byte, then
//    moves into the output register when that register is empty or being taken.
//  - A receiver stall fills the result queue (QUEUE_DEPTH entries) and the output
//    register; s_tready drops only when the queue is full. Skipped or header bytes
//    make no result and are accepted freely while space remains.
//  - Reset (aresetn low, synchronous) clears buffer_length, parser state, queue
//    and output valid. After each closing byte the parser returns to its start
//    state on its own; buffer_length keeps its value.
//  - Status: 0 ok, 1 stopped on bad length, 2 too short, 3 not video PES.
module pes_video_payload_extractor_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // APB configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pvpe_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pvpe_pkg::TDATA_IN_W-1:0]    s_tdata,   // [7:0] data_byte
    input  logic                               s_tlast,   // last
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pvpe_pkg::TDATA_OUT_W-1:0]   m_tdata,   // [7:0] payload_byte,
                                                          // [23:8] payload_length,
                                                          // [25:24] status, zero above
    output logic                               m_tuser,   // [0] has_byte
    output logic                               m_tlast    // is_end
);
    import pvpe_pkg::*;

    logic [15:0] buf_len_reg;
    logic        cfg_wr;
    logic        q_full;
    logic        q_not_empty;
    logic        q_pop;
    logic        res_valid;
    result_t     res;
    result_t     q_data;

    // config register: written in the APB access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_len_reg <= 16'd0;
        end else if (cfg_wr && paddr[2] == REG_IDX_BUF_LEN) begin
            buf_len_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_IDX_BUF_LEN) ? {16'b0, buf_len_reg} : 32'd0;

    // front end takes a byte whenever the queue has room
    assign s_tready = !q_full;

    pvpe_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_len   (buf_len_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .res_valid (res_valid),
        .res       (res)
    );

    pvpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rd_data   (q_data)
    );

    pvpe_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_not_empty),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* test/testbench.sv */
// Self-checking testbench of the PES payload extractor: directed and random buffers in, results checked.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pvpe_pkg::*;

    localparam int          RANDOM_ITEMS  = 1600;
    localparam int          SETTLE_CYCLES = 4;     // results pass through queue and output register
    localparam int          DRAIN_CYCLES  = 16;
    localparam int          MAX_REPORTS   = 40;
    localparam logic [7:0]  TS_SYNC       = 8'h47;
    localparam logic [7:0]  MARKER_BYTE   = 8'h0F;

    // one pending request of the input side: a register write or one buffer byte
    typedef struct {
        bit          is_cfg;
        bit          hold;      // wait for every outstanding result before sending
        logic [15:0] value;
        logic [7:0]  data;
        bit          is_last;
    } feed_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr = {REG_IDX_BUF_LEN, 2'b00};
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    feed_t       pending_q[$];
    result_t     result_q[$];
    logic [7:0]  frame[$];
    int          sent_count  = 0;
    int          taken_count = 0;
    int          fail_count  = 0;
    int          gap_left    = 0;
    int          stall_left  = 0;
    int          settle_left = SETTLE_CYCLES;
    int          calm_left[2] = '{0, 0};

    // shadow of the parser
    logic [15:0] len_reg   = '0;
    logic [15:0] pos_q     = '0;
    logic [23:0] window_q  = WINDOW_IDLE;
    phase_t      phase_q   = PH_FIRST;
    logic [16:0] pkt_left  = '0;
    logic [16:0] hdr_left  = '0;
    logic [7:0]  sid_q     = '0;
    logic [15:0] out_count = '0;
    logic [1:0]  stop_code = ST_OK;

    pes_video_payload_extractor_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- parser shadow

    function automatic void clear_parse();
        pos_q     = '0;
        window_q  = WINDOW_IDLE;
        phase_q   = PH_FIRST;
        pkt_left  = '0;
        hdr_left  = '0;
        sid_q     = '0;
        out_count = '0;
        stop_code = ST_OK;
    endfunction

    function automatic void go_scan();
        window_q = WINDOW_IDLE;
        phase_q  = PH_SCAN;
    endfunction

    function automatic void stop_parse(logic [1:0] st);
        stop_code = st;
        phase_q   = PH_HALT;
    endfunction

    function automatic void shift_in(logic [7:0] b);
        window_q = {window_q[15:0], b};
    endfunction

    // header done: check that the payload fits, then skip the rest of the header
    function automatic void end_header(int offs, int len, int skip, int lim);
        if (len < 0 || int'(out_count) + len > lim || offs + len > lim) begin
            stop_parse(ST_BAD_LEN);
            return;
        end
        pkt_left = 17'(len);
        hdr_left = 17'(skip);
        if (skip > 0)
            phase_q = PH_HDRSKIP;
        else if (len > 0)
            phase_q = PH_PAYLOAD;
        else
            go_scan();
    endfunction

    function automatic void mpeg1_pts(logic [7:0] b, int p, int lim);
        int len;
        len = int'(pkt_left);
        if (p + 5 <= lim && len >= 5 && b[7:4] == PTS_NIB)
            end_header(p + 5, len - 5, 4, lim);
        else if (p + 10 <= lim && len >= 10 && b[7:4] == PTSDTS_NIB)
            end_header(p + 10, len - 10, 9, lim);
        else if (len > 0)
            end_header(p + 1, len - 1, 0, lim);
        else begin
            // empty packet: this byte already belongs to the scan
            window_q = {16'hFFFF, b};
            phase_q  = PH_SCAN;
        end
    endfunction

    function automatic void mpeg1_std(logic [7:0] b, int p, int lim);
        if (p + 2 <= lim && pkt_left >= 2 && b[7:6] == STD_MARK) begin
            pkt_left = pkt_left - 2;
            phase_q  = PH_M1STD;
        end else begin
            mpeg1_pts(b, p, lim);
        end
    endfunction

    function automatic void mpeg1_stuff(logic [7:0] b, int p, int lim);
        if (pkt_left > 0 && b == STUFF_BYTE) begin
            pkt_left = pkt_left - 1;
            phase_q  = PH_M1STUFF;
        end else begin
            mpeg1_std(b, p, lim);
        end
    endfunction

    // one accepted byte; returns 1 when it makes a result
    function automatic bit extract_byte(logic [7:0] b, bit is_last, output result_t res);
        int         p;
        int         lim;
        bit         emit;
        logic [7:0] ob;
        logic [1:0] st;
        p    = int'(pos_q);
        lim  = int'(len_reg);
        emit = 1'b0;
        ob   = '0;
        res  = '0;
        if (lim > MAX_BUFFER)
            lim = MAX_BUFFER;

        if (phase_q == PH_FIRST && p == 0 && lim < MIN_LENGTH)
            stop_parse(ST_SHORT);

        if (p < lim && phase_q != PH_HALT) begin
            case (phase_q)
                PH_FIRST: begin
                    shift_in(b);
                    if (p < 2) begin
                        if (b != 8'h00) stop_parse(ST_NOT_PES);
                    end else if (p == 2) begin
                        if (b != START_CODE[7:0]) stop_parse(ST_NOT_PES);
                    end else if (b[7:4] != VIDEO_NIB) begin
                        stop_parse(ST_NOT_PES);
                    end else begin
                        sid_q   = b;
                        phase_q = (lim > 6) ? PH_LENHI : PH_SCAN;
                    end
                end
                PH_SCAN: begin
                    shift_in(b);
                    if (window_q == START_CODE && p + 4 < lim)
                        phase_q = PH_ID;
                end
                PH_ID: begin
                    shift_in(b);
                    sid_q = b;
                    if (b[7:4] == VIDEO_NIB || (b >= PRIV_ID_LO && b <= PRIV_ID_HI))
                        phase_q = PH_LENHI;
                    else
                        phase_q = PH_SCAN;
                end
                PH_LENHI: begin
                    pkt_left = {1'b0, b, 8'h00};
                    phase_q  = PH_LENLO;
                end
                PH_LENLO: begin
                    pkt_left[7:0] = b;
                    if (sid_q[7:4] == VIDEO_NIB) begin
                        phase_q = PH_HDR;
                    end else if (pkt_left == 0) begin
                        go_scan();
                    end else begin
                        hdr_left = pkt_left;
                        phase_q  = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    hdr_left = hdr_left - 1;
                    if (hdr_left == 0)
                        go_scan();
                end
                PH_HDR: begin
                    if (b[7:6] == M2_MARK)
                        phase_q = PH_M2FLAGS;
                    else
                        mpeg1_stuff(b, p, lim);
                end
                PH_M2FLAGS: phase_q = PH_M2HLEN;
                PH_M2HLEN: begin
                    if (int'(b) >= lim)
                        stop_parse(ST_BAD_LEN);
                    else
                        end_header(p + 1 + int'(b), int'(pkt_left) - 3 - int'(b),
                                   int'(b), lim);
                end
                PH_M1STUFF: mpeg1_stuff(b, p, lim);
                PH_M1STD:   phase_q = PH_M1PTS;
                PH_M1PTS:   mpeg1_pts(b, p, lim);
                PH_HDRSKIP: begin
                    hdr_left = hdr_left - 1;
                    if (hdr_left == 0) begin
                        if (pkt_left > 0)
                            phase_q = PH_PAYLOAD;
                        else
                            go_scan();
                    end
                end
                PH_PAYLOAD: begin
                    emit      = 1'b1;
                    ob        = b;
                    out_count = out_count + 1'b1;
                    pkt_left  = pkt_left - 1;
                    if (pkt_left == 0)
                        go_scan();
                end
                default: stop_parse(ST_BAD_LEN);
            endcase
        end

        if (pos_q != 16'hFFFF)
            pos_q = pos_q + 1'b1;

        if (!emit && !is_last)
            return 1'b0;

        res.payload_byte = ob;
        res.has_byte     = emit;
        res.is_end       = is_last;
        if (is_last) begin
            st = stop_code;
            if (st == ST_OK) begin
                // an unfinished video packet counts as a bad length
                case (phase_q)
                    PH_FIRST: st = ST_NOT_PES;
                    PH_HDR, PH_M2FLAGS, PH_M2HLEN, PH_M1STD, PH_HDRSKIP, PH_PAYLOAD:
                        st = ST_BAD_LEN;
                    PH_M1STUFF, PH_M1PTS:
                        if (pkt_left > 0) st = ST_BAD_LEN;
                    default: ;
                endcase
            end
            res.payload_length = out_count;
            res.status         = st;
            clear_parse();
        end
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- stimulus

    // idle length for either side (0: sender, 1: receiver), mostly short
    function automatic int gap_len(int side);
        int r;
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 249) == 0)
            calm_left[side] = $urandom_range(40, 160);
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void put_start(logic [7:0] id);
        frame.push_back(START_CODE[23:16]);
        frame.push_back(START_CODE[15:8]);
        frame.push_back(START_CODE[7:0]);
        frame.push_back(id);
    endfunction

    function automatic void put_random(int n);
        repeat (n) frame.push_back(8'($urandom));
    endfunction

    // config write, then the framed bytes with tlast on the final one
    function automatic void queue_buffer(int reg_len, int hold_at);
        feed_t f;
        f        = '{default: '0};
        f.is_cfg = 1'b1;
        f.value  = 16'(reg_len);
        pending_q.push_back(f);
        foreach (frame[i]) begin
            f         = '{default: '0};
            f.data    = frame[i];
            f.is_last = (i == frame.size() - 1);
            f.hold    = (i == hold_at);
            pending_q.push_back(f);
        end
        frame.delete();
    endfunction

    function automatic void add_video_pes();
        logic [7:0] hdr[$];
        int         pay;
        int         hlen;
        int         plen;
        int         sel;
        pay = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
        if ($urandom_range(0, 19) == 0) begin
            plen = 0;   // empty packet
            pay  = 0;
        end else begin
            if ($urandom_range(0, 1) == 1) begin
                // MPEG-2 header: flags, flags, header length, extension
                hlen = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 255)
                                                    : $urandom_range(0, 8);
                hdr.push_back({M2_MARK, 6'($urandom)});
                hdr.push_back(8'($urandom));
                hdr.push_back(8'(hlen));
                repeat (hlen) hdr.push_back(8'($urandom));
            end else begin
                // MPEG-1: stuffing, optional STD, then PTS, PTS+DTS or marker
                repeat ($urandom_range(0, 3)) hdr.push_back(STUFF_BYTE);
                if ($urandom_range(0, 1) == 1) begin
                    hdr.push_back({STD_MARK, 6'($urandom)});
                    hdr.push_back(8'($urandom));
                end
                sel = $urandom_range(0, 2);
                if (sel == 0) begin
                    hdr.push_back({PTS_NIB, 4'($urandom)});
                    repeat (4) hdr.push_back(8'($urandom));
                end else if (sel == 1) begin
                    hdr.push_back({PTSDTS_NIB, 4'($urandom)});
                    repeat (9) hdr.push_back(8'($urandom));
                end else begin
                    hdr.push_back(MARKER_BYTE);
                end
            end
            plen = hdr.size() + pay;
            if ($urandom_range(0, 11) == 0)
                plen = ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, 65535))
                                                   : plen + $urandom_range(0, 6) - 3;
            if (plen < 0)
                plen = 0;
        end
        put_start({VIDEO_NIB, 4'($urandom)});
        frame.push_back(8'(plen >> 8));
        frame.push_back(8'(plen));
        foreach (hdr[i]) frame.push_back(hdr[i]);
        put_random(pay);
    endfunction

    function automatic void add_private();
        int n;
        n = $urandom_range(0, 30);
        put_start(8'($urandom_range(PRIV_ID_LO, PRIV_ID_HI)));
        frame.push_back(8'(n >> 8));
        frame.push_back(8'(n));
        put_random(n);
    endfunction

    function automatic logic [7:0] foreign_id();
        logic [7:0] id;
        do
            id = 8'($urandom);
        while (id[7:4] == VIDEO_NIB || (id >= PRIV_ID_LO && id <= PRIV_ID_HI));
        return id;
    endfunction

    // a buffer of packets; returns its byte count
    function automatic int build_stream();
        int target;
        int reg_len;
        int hold_at;
        int k;
        target = ($urandom_range(0, 9) == 0) ? $urandom_range(300, 1200)
                                             : $urandom_range(MIN_LENGTH, 280);
        add_video_pes();
        while (frame.size() < target) begin
            k = $urandom_range(0, 9);
            if (k < 6)
                add_video_pes();
            else if (k < 8)
                add_private();
            else if (k == 8) begin
                put_start(foreign_id());
                put_random($urandom_range(0, 4));
            end else
                put_random($urandom_range(1, 6));
        end
        // either cut mid-packet or end on a packet boundary
        if ($urandom_range(0, 2) != 0)
            while (frame.size() > target) void'(frame.pop_back());
        else
            target = frame.size();
        if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, 3)) frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
        k = $urandom_range(0, 9);
        if (k == 0)
            reg_len = target + $urandom_range(1, 40);      // tlast comes early
        else if (k == 1)
            reg_len = $urandom_range(MIN_LENGTH, target);  // bytes past the end
        else
            reg_len = target;
        if (reg_len > 65535)
            reg_len = 65535;
        hold_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, frame.size() - 1) : -1;
        queue_buffer(reg_len, hold_at);
        return target;
    endfunction

    function automatic void build_short();
        if ($urandom_range(0, 1) == 1)
            put_start({VIDEO_NIB, 4'($urandom)});
        put_random($urandom_range(1, 8));
        queue_buffer($urandom_range(0, MIN_LENGTH - 1), -1);
    endfunction

    function automatic void build_bad_start();
        case ($urandom_range(0, 3))
            0: frame.push_back(TS_SYNC);
            1: put_start(foreign_id());
            2: begin
                frame.push_back(8'h00);
                frame.push_back(8'h00);
                frame.push_back(8'($urandom_range(2, 255)));
            end
            default: frame.push_back(8'($urandom_range(1, 255)));
        endcase
        put_random($urandom_range(0, 6));
        queue_buffer($urandom_range(MIN_LENGTH, 65535), -1);
    endfunction

    function automatic void build_directed();
        // zero length: too short
        frame = '{8'h00};
        queue_buffer(0, -1);
        // TS sync byte at full length: not a video PES
        frame = '{TS_SYNC, 8'hFF};
        queue_buffer(65535, -1);
        // tlast inside the start code
        frame = '{8'h00, 8'h00, START_CODE[7:0]};
        queue_buffer(MIN_LENGTH, -1);
        // one payload byte, then tlast mid-payload
        put_start(8'hE0);
        frame.push_back(8'h00);
        frame.push_back(8'h05);
        frame.push_back({M2_MARK, 6'h00});
        frame.push_back(8'h00);
        frame.push_back(8'h00);
        frame.push_back(8'hAA);
        queue_buffer(200, -1);
        // maximum packet length in a maximum buffer: payload passes the end
        put_start(8'hEF);
        frame.push_back(8'hFF);
        frame.push_back(8'hFF);
        frame.push_back({M2_MARK, 6'h3F});
        frame.push_back(8'h00);
        frame.push_back(8'h00);
        frame.push_back(8'h7A);
        queue_buffer(65535, -1);
    endfunction

    // ---------------------------------------------------------------- driver

    always @(negedge aclk) begin : drive
        feed_t       nx_req;
        logic        nx_valid;
        logic        nx_last;
        logic [7:0]  nx_data;
        logic        nx_psel;
        logic        nx_penable;
        logic        nx_pwrite;
        logic [31:0] nx_pwdata;
        nx_valid   = s_tvalid;
        nx_last    = s_tlast;
        nx_data    = s_tdata;
        nx_psel    = psel;
        nx_penable = penable;
        nx_pwrite  = pwrite;
        nx_pwdata  = pwdata;
        if (!aresetn) begin
            // stay idle
        end else if (s_tvalid && taken_count != sent_count) begin
            // request still waiting for s_tready
        end else if (psel && !penable) begin
            nx_penable = 1'b1;  // APB access phase
        end else begin
            nx_valid   = 1'b0;
            nx_psel    = 1'b0;
            nx_penable = 1'b0;
            nx_pwrite  = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_q.size() != 0) begin
                nx_req = pending_q[0];
                // writes and held bytes wait for an empty pipeline
                if ((nx_req.is_cfg || nx_req.hold)
                    && (result_q.size() != 0 || settle_left > 0)) begin
                    if (result_q.size() == 0)
                        settle_left--;
                end else begin
                    pending_q.delete(0);
                    settle_left = SETTLE_CYCLES;
                    if (nx_req.is_cfg) begin
                        nx_psel   = 1'b1;
                        nx_pwrite = 1'b1;
                        nx_pwdata = {16'h0000, nx_req.value};
                    end else begin
                        nx_valid = 1'b1;
                        nx_data  = nx_req.data;
                        nx_last  = nx_req.is_last;
                        sent_count++;
                        gap_left = gap_len(0);
                    end
                end
            end
        end
        s_tvalid <= nx_valid;
        s_tlast  <= nx_last;
        s_tdata  <= nx_data;
        psel     <= nx_psel;
        penable  <= nx_penable;
        pwrite   <= nx_pwrite;
        pwdata   <= nx_pwdata;
    end

    always @(negedge aclk) begin : rx_pace
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            stall_left = gap_len(1);
        end
    end

    // ---------------------------------------------------------------- monitor

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            if (fail_count < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : scoreboard
        result_t want;
        result_t next_res;
        if (!aresetn) begin
            len_reg = '0;
            clear_parse();
        end else begin
            // results first: none of them can stem from a byte taken at this edge
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    if (fail_count < MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, %s %0h %0b %0b",
                                 $time, "actual tdata tuser tlast", m_tdata, m_tuser,
                                 m_tlast);
                    fail_count++;
                end else begin
                    want = result_q.pop_front();
                    check_field("payload_byte", want.payload_byte, m_tdata[7:0]);
                    check_field("payload_length", want.payload_length, m_tdata[23:8]);
                    check_field("status", want.status, m_tdata[25:24]);
                    check_field("tdata padding", 0, m_tdata[31:26]);
                    check_field("has_byte", want.has_byte, m_tuser);
                    check_field("is_end", want.is_end, m_tlast);
                end
            end
            if (s_tvalid && s_tready) begin
                taken_count++;
                if (extract_byte(s_tdata, s_tlast, next_res))
                    result_q.push_back(next_res);
            end
            if (psel && penable && pwrite && pready)
                len_reg = pwdata[15:0];
        end
    end

    // ---------------------------------------------------------------- run control

    initial begin : run
        int counted;
        int k;
        counted = 0;
        build_directed();
        while (counted < RANDOM_ITEMS) begin
            k = $urandom_range(0, 9);
            if (k < 8)
                counted += build_stream();
            else if (k == 8)
                build_short();
            else
                build_bad_start();
        end
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        while (pending_q.size() != 0 || taken_count != sent_count || result_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("[pes_video_payload_extractor_core] OK");
        else
            $display("[pes_video_payload_extractor_core] ERROR");
        $finish;
    end

    initial begin : watchdog
        #8000000;
        $display("[pes_video_payload_extractor_core] ERROR");
        $finish;
    end

endmodule
